// ===== rtl/ffra_pkg.sv =====
// ffra_pkg: shared types, codes and defaults for the first-fit region allocator
// no dependencies; imported by first_fit_region_allocator
package ffra_pkg;

   localparam int MaxHolesDefault = 16;
   localparam int PageBitsDefault = 12;
   localparam int AddrBitsDefault = 32;

   // request kinds
   typedef enum logic [1:0] {
      FUNC_ADD   = 2'd0,
      FUNC_ALLOC = 2'd1,
      FUNC_RSV   = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   // result codes
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_FIT   = 2'd1,
      ST_NOT_FND  = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] region_address;
      logic [31:0] region_size;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] granted_address;
   } rsp_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_CHECK,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_DONE
   } state_type;

endpackage

// ===== rtl/first_fit_region_allocator.sv =====
// first_fit_region_allocator: ordered hole table in two synchronous memories
// with a scan / modify / shift sequencer; depends on ffra_pkg
//
//  channel | dir | handshake        | payload
//  req     | in  | req_valid/stall  | req_type: func, region_address, region_size
//  rsp     | out | rsp_valid/stall  | rsp_type: status, granted_address
//
// one item at a time; add hole writes its entry straight from idle when the table has
// room, allocate and reserve read and check one hole per scan step (up to hole_count),
// and every entry moved when a hole is removed or split takes a read and then a write;
// the registered memory read sets the pace.
// synchronous reset clears only the control state and the hole count.
// a stalled result holds in the output register; a new item is taken once
// the result register is free.
module first_fit_region_allocator
   import ffra_pkg::*;
#(
   parameter int MAX_HOLES = MaxHolesDefault,
   parameter int PAGE_BITS = PageBitsDefault,
   parameter int ADDR_BITS = AddrBitsDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IW = (MAX_HOLES > 2) ? $clog2(MAX_HOLES) : 1;
   localparam int CW = $clog2(MAX_HOLES + 1);
   localparam int AW = (ADDR_BITS < 32) ? ADDR_BITS : 32;
   localparam logic [32:0] PG_MASK = 33'((64'd1 << PAGE_BITS) - 64'd1);
   localparam logic [32:0] ADDR_MASK = 33'(64'hFFFF_FFFF >> (32 - AW));

   // hole memories
   logic [31:0] base_mem [MAX_HOLES];
   logic [31:0] len_mem  [MAX_HOLES];
   logic [31:0] rd_base_ff, rd_len_ff;

   state_type   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] sh_ff, sh_in;
   logic        shift_up_ff, shift_up_in;
   logic [1:0]  func_ff, func_in;
   logic [32:0] addr_ff, addr_in;
   logic [32:0] rsz_ff, rsz_in;
   logic [31:0] ins_base_ff, ins_base_in;
   logic [31:0] ins_len_ff, ins_len_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   // memory port controls
   logic          rd_en, wr_en;
   logic [IW-1:0] rd_addr, wr_addr;
   logic [31:0]   wr_base, wr_len;

   logic [32:0] hb, he, end_a;
   logic        accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign hb    = {1'b0, rd_base_ff};
   assign he    = hb + {1'b0, rd_len_ff};
   assign end_a = addr_ff + rsz_ff;

   // memory access
   always_ff @(posedge clock) begin
      if (wr_en) begin
         base_mem[wr_addr] <= wr_base;
         len_mem[wr_addr]  <= wr_len;
      end
      if (rd_en) begin
         rd_base_ff <= base_mem[rd_addr];
         rd_len_ff  <= len_mem[rd_addr];
      end
   end

   // control and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      sh_ff       <= sh_in;
      shift_up_ff <= shift_up_in;
      func_ff     <= func_in;
      addr_ff     <= addr_in;
      rsz_ff      <= rsz_in;
      ins_base_ff <= ins_base_in;
      ins_len_ff  <= ins_len_in;
      rsp_ff      <= rsp_in;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      sh_in        = sh_ff;
      shift_up_in  = shift_up_ff;
      func_in      = func_ff;
      addr_in      = addr_ff;
      rsz_in       = rsz_ff;
      ins_base_in  = ins_base_ff;
      ins_len_in   = ins_len_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rd_en   = 1'b0;
      wr_en   = 1'b0;
      rd_addr = idx_ff[IW-1:0];
      wr_addr = idx_ff[IW-1:0];
      wr_base = '0;
      wr_len  = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in = req_data.func;
               addr_in = ({1'b0, req_data.region_address} & ADDR_MASK) & ~PG_MASK;
               rsz_in  = ({1'b0, req_data.region_size} + PG_MASK) & ~PG_MASK;
               idx_in  = '0;
               rsp_in.status          = ST_OK;
               rsp_in.granted_address = '0;
               case (func_type'(req_data.func))
                  FUNC_ADD: begin
                     if (count_ff >= CW'(MAX_HOLES)) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[IW-1:0];
                        wr_base  = 32'({1'b0, req_data.region_address} & ADDR_MASK);
                        wr_len   = req_data.region_size;
                        count_in = count_ff + 1'b1;
                     end
                     state_in = S_DONE;
                  end
                  FUNC_ALLOC, FUNC_RSV: begin
                     state_in = S_SCAN;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_SCAN: begin
            // read next hole or give up
            if (idx_ff >= count_ff) begin
               rsp_in.status = (func_ff == FUNC_ALLOC) ? ST_NO_FIT : ST_NOT_FND;
               state_in = S_DONE;
            end else begin
               rd_en    = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = S_SCAN;
            idx_in   = idx_ff + 1'b1;
            if (func_ff == FUNC_ALLOC) begin
               if (rsz_ff <= {1'b0, rd_len_ff}) begin
                  rsp_in.granted_address = rd_base_ff;
                  state_in = S_DONE;
                  idx_in   = idx_ff;
                  if (rsz_ff == {1'b0, rd_len_ff}) begin
                     // exact fit: close the gap
                     sh_in       = idx_ff;
                     shift_up_in = 1'b0;
                     state_in    = S_SHIFT_RD;
                  end else begin
                     wr_en   = 1'b1;
                     wr_base = 32'((hb + rsz_ff) & ADDR_MASK);
                     wr_len  = 32'({1'b0, rd_len_ff} - rsz_ff);
                  end
               end
            end else if (hb <= addr_ff && end_a <= he) begin
               state_in = S_DONE;
               idx_in   = idx_ff;
               wr_en    = 1'b1;
               if (hb == addr_ff) begin
                  wr_base = 32'(end_a & ADDR_MASK);
                  wr_len  = 32'(he - end_a);
               end else if (he == end_a) begin
                  wr_base = rd_base_ff;
                  wr_len  = 32'(addr_ff - hb);
               end else if (count_ff >= CW'(MAX_HOLES)) begin
                  wr_en = 1'b0;
                  rsp_in.status = ST_FULL;
               end else begin
                  // split: open a slot after this hole
                  wr_base     = rd_base_ff;
                  wr_len      = 32'(addr_ff - hb);
                  ins_base_in = 32'(end_a & ADDR_MASK);
                  ins_len_in  = 32'(he - end_a);
                  sh_in       = count_ff;
                  shift_up_in = 1'b1;
                  state_in    = S_SHIFT_RD;
               end
            end
         end
         S_SHIFT_RD: begin
            if (shift_up_ff) begin
               if (sh_ff == idx_ff + 1'b1) begin
                  wr_en    = 1'b1;
                  wr_addr  = sh_ff[IW-1:0];
                  wr_base  = ins_base_ff;
                  wr_len   = ins_len_ff;
                  count_in = count_ff + 1'b1;
                  state_in = S_DONE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = IW'(sh_ff - 1'b1);
                  state_in = S_SHIFT_WR;
               end
            end else begin
               if (sh_ff + 1'b1 >= count_ff) begin
                  count_in = count_ff - 1'b1;
                  state_in = S_DONE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = IW'(sh_ff + 1'b1);
                  state_in = S_SHIFT_WR;
               end
            end
         end
         S_SHIFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = sh_ff[IW-1:0];
            wr_base = rd_base_ff;
            wr_len  = rd_len_ff;
            sh_in   = shift_up_ff ? sh_ff - 1'b1 : sh_ff + 1'b1;
            state_in = S_SHIFT_RD;
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hole count never exceeds the table size
   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(MAX_HOLES))
      else $error("hole count overflow");
   // no new item while a result is pending
   assert property (@(posedge clock) disable iff (reset) rsp_valid_ff |-> req_stall)
      else $error("item taken with result pending");
   // a result appears only after the done state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result without completion");
   // memory is never written while idle without an accepted item
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !accept) |-> !wr_en)
      else $error("spurious memory write");

endmodule
